// File: rtl/sync_length_frame_receiver_macros.svh
// Assertion macros shared by the frame receiver modules.
`ifndef SYNC_LENGTH_FRAME_RECEIVER_MACROS_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLFR_ASSERT_NOW(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLFR_ASSERT_NEXT(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error(msg);

`endif

// File: rtl/slfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slfr_pkg;

  localparam logic [7:0] SYNC_RESET = 8'hAA;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_LEN_HI = 4'b0010,
    PH_LEN_LO = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        last;
    logic        ok;
    logic [15:0] length;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/slfr_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module slfr_skid (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire slfr_pkg::result_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output slfr_pkg::result_t     out_data
);
  import slfr_pkg::*;
  `include "sync_length_frame_receiver_macros.svh"

  logic    main_valid;
  logic    spare_valid;
  result_t main_data;
  result_t spare_data;
  logic    push;
  logic    pop;

  assign in_ready  = !spare_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign push      = in_valid && in_ready;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else begin
      if (!main_valid || pop) begin
        if (spare_valid) begin
          main_data   <= spare_data;
          spare_valid <= 1'b0;
        end else if (push) begin
          main_data  <= in_data;
          main_valid <= 1'b1;
        end else begin
          main_valid <= 1'b0;
        end
      end else if (push) begin
        spare_data  <= in_data;
        spare_valid <= 1'b1;
      end
    end
  end

  `SLFR_ASSERT_NOW(a_spare_needs_main, spare_valid, main_valid, "spare held without main")
  `SLFR_ASSERT_NOW(a_no_push_when_full, in_valid, in_ready, "result offered to full buffer")
  `SLFR_ASSERT_NEXT(a_stall_fills_spare, main_valid && !out_ready && push, spare_valid,
                    "stalled push not held in spare")

endmodule

`default_nettype wire

// File: rtl/slfr_core.sv
`timescale 1ns / 1ps
`default_nettype none

module slfr_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_write,
  input  wire logic [7:0]   cfg_data,
  input  wire logic         beat,
  input  wire logic [7:0]   rx_byte,
  output logic              res_valid,
  output slfr_pkg::result_t res
);
  import slfr_pkg::*;
  `include "sync_length_frame_receiver_macros.svh"

  logic [7:0]  sync_byte;
  phase_t      phase;
  phase_t      phase_next;
  logic [7:0]  length_high;
  logic [7:0]  length_high_next;
  logic [16:0] remaining;
  logic [16:0] remaining_next;
  logic [7:0]  running_sum;
  logic [7:0]  running_sum_next;
  logic [15:0] payload_length;
  logic [15:0] payload_length_next;
  logic        emit;

  always_comb begin
    phase_next          = phase;
    length_high_next    = length_high;
    remaining_next      = remaining;
    running_sum_next    = running_sum;
    payload_length_next = payload_length;
    emit                = 1'b0;
    res.kind            = KIND_PAYLOAD;
    res.data            = rx_byte;
    res.last            = 1'b0;
    res.ok              = 1'b0;
    res.length          = payload_length;
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == sync_byte) begin
          phase_next = PH_LEN_HI;
        end else begin
          emit       = 1'b1;
          res.kind   = KIND_DISCARD;
          res.length = 16'd0;
        end
      end
      PH_LEN_HI: begin
        length_high_next = rx_byte;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_length_next = {length_high, rx_byte};
        remaining_next      = {1'b0, length_high, rx_byte} + 17'd1;
        running_sum_next    = 8'd0;
        phase_next          = PH_BODY;
      end
      PH_BODY: begin
        emit = 1'b1;
        if (remaining > 17'd1) begin
          running_sum_next = running_sum + rx_byte;
          remaining_next   = remaining - 17'd1;
        end else begin
          res.kind         = KIND_END;
          res.last         = 1'b1;
          res.ok           = (running_sum == rx_byte);
          remaining_next   = 17'd0;
          running_sum_next = 8'd0;
          phase_next       = PH_HUNT;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  assign res_valid = beat && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte      <= SYNC_RESET;
      phase          <= PH_HUNT;
      length_high    <= 8'd0;
      remaining      <= 17'd0;
      running_sum    <= 8'd0;
      payload_length <= 16'd0;
    end else begin
      if (cfg_write) begin
        sync_byte <= cfg_data;
      end
      if (beat) begin
        phase          <= phase_next;
        length_high    <= length_high_next;
        remaining      <= remaining_next;
        running_sum    <= running_sum_next;
        payload_length <= payload_length_next;
      end
    end
  end

  `SLFR_ASSERT_NOW(a_body_count_live, phase == PH_BODY, remaining != 17'd0,
                   "payload phase with empty count")
  `SLFR_ASSERT_NEXT(a_end_returns_hunt, beat && phase == PH_BODY && remaining <= 17'd1,
                    phase == PH_HUNT && running_sum == 8'd0, "frame end did not rearm hunt")
  `SLFR_ASSERT_NEXT(a_header_opens_body, beat && phase == PH_LEN_LO,
                    phase == PH_BODY && running_sum == 8'd0 && remaining != 17'd0,
                    "header did not open payload")

endmodule

`default_nettype wire

// File: rtl/sync_length_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// Sync-byte framed receiver: hunts for the sync byte, reads a big-endian
// 16-bit payload length, passes each payload byte out as it arrives and closes
// the frame on the checksum byte with the length and an 8-bit sum check.
// Bytes seen while hunting come out marked as discarded; sync and length bytes
// give no output beat. One byte is taken every clock cycle: the parser state
// steps once per input beat, and results sit in a two-entry output buffer
// whose registered ready is the input ready, so output stalls hold the input
// back only once that buffer is full. Each result is registered in that buffer
// before it reaches the output. The sync byte register resets to 0xAA and may
// be written at any time the block is idle.
module sync_length_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,       // sync_byte
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] data, [8] checksum_ok,
                                           // [24:9] frame_length, [31:25] zero
  output logic             m_axis_tlast,   // frame_last
  output logic [1:0]       m_axis_tuser    // [1:0] kind
);
  import slfr_pkg::*;

  logic    beat;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign beat      = s_axis_tvalid && s_axis_tready;

  slfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .beat      (beat),
    .rx_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  slfr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (s_axis_tready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {7'd0, out_res.length, out_res.ok, out_res.data};
  assign m_axis_tlast = out_res.last;
  assign m_axis_tuser = out_res.kind;

endmodule

`default_nettype wire
